// ----- rtl/mcrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the message cache ring check block.
package mcrc_pkg;

    localparam int CACHE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(CACHE_DEPTH);
    localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);
    localparam int CFG_W       = 6;
    localparam int VCNT_W      = 6;
    localparam int MODE_W      = 2;
    localparam int SRC_W       = 16;
    localparam int SEQ_W       = 24;
    localparam int KEY_W       = SRC_W + SEQ_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_CHECK = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_step;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              len_zero;
        logic              scan_last;
        logic              out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] ring_size(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] n;
        if (cfg == '0) begin
            n = CNT_W'(1);
        end else if (int'(cfg) > CACHE_DEPTH) begin
            n = CNT_W'(CACHE_DEPTH);
        end else begin
            n = CNT_W'(cfg);
        end
        return n;
    endfunction

endpackage

// ----- rtl/mcrc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mcrc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences accept, execute, scan and result beats.
module mcrc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  mcrc_pkg::t_sts i_sts,
    output mcrc_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_LAST,
        ST_RESULT
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_in_stall;
    mcrc_pkg::t_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_sts.mode)
                    mcrc_pkg::MODE_ADD, mcrc_pkg::MODE_CLEAR: begin
                        n_cmd.exec = 1'b1;
                        n_state    = ST_RESULT;
                    end
                    mcrc_pkg::MODE_CHECK: begin
                        n_state = i_sts.len_zero ? ST_RESULT : ST_SCAN;
                    end
                    default: begin
                        n_state = ST_RESULT;
                    end
                endcase
            end
            ST_SCAN: begin
                n_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    n_cmd.result_load = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;
    assign o_cmd      = n_cmd;

    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> r_in_stall)
        else $error("input not stalled while busy");

    a_load_leads_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EXEC))
        else $error("accepted beat not executed");

    a_result_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result_load |-> i_sts.out_free)
        else $error("result loaded over a held beat");

endmodule

// ----- rtl/mcrc_dp.sv -----
`timescale 1ns / 1ps
// Datapath: ring state, entry memory, scan compare and output register.
module mcrc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mcrc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [mcrc_pkg::MODE_W-1:0]  i_mode,
    input  logic [mcrc_pkg::SRC_W-1:0]   i_src,
    input  logic [mcrc_pkg::SEQ_W-1:0]   i_seq,
    input  mcrc_pkg::t_cmd               i_cmd,
    output mcrc_pkg::t_sts               o_sts,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_not_seen,
    output logic [mcrc_pkg::VCNT_W-1:0]  o_valid_count
);

    logic [mcrc_pkg::CFG_W-1:0]  r_cfg;
    logic [mcrc_pkg::CNT_W-1:0]  r_wp;
    logic                        r_wrap;
    logic [mcrc_pkg::MODE_W-1:0] r_mode;
    logic [mcrc_pkg::KEY_W-1:0]  r_key;
    logic [mcrc_pkg::CNT_W-1:0]  r_scan_idx;
    logic                        r_rd_pend;
    logic                        r_not_seen;
    logic                        r_out_valid;
    logic                        r_out_not_seen;
    logic [mcrc_pkg::VCNT_W-1:0] r_out_count;

    logic [mcrc_pkg::CNT_W-1:0]  ring_n;
    logic [mcrc_pkg::CNT_W-1:0]  len;
    logic [mcrc_pkg::CNT_W-1:0]  wp_eff;
    logic                        add_wraps;
    logic                        ram_we;
    logic [mcrc_pkg::KEY_W-1:0]  ram_rdata;
    logic                        out_free;

    assign ring_n    = mcrc_pkg::ring_size(r_cfg);
    assign len       = r_wrap ? ring_n : ((r_wp < ring_n) ? r_wp : ring_n);
    assign add_wraps = (r_wp >= ring_n);
    assign wp_eff    = add_wraps ? '0 : r_wp;
    assign ram_we    = i_cmd.exec && (r_mode == mcrc_pkg::MODE_ADD);
    assign out_free  = !r_out_valid || !i_out_stall;

    mcrc_ram #(
        .WIDTH (mcrc_pkg::KEY_W),
        .DEPTH (mcrc_pkg::CACHE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wp_eff[mcrc_pkg::ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_scan_idx[mcrc_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= mcrc_pkg::CFG_RESET;
            r_wp        <= '0;
            r_wrap      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                if (r_mode == mcrc_pkg::MODE_ADD) begin
                    r_wp <= wp_eff + 1'b1;
                    if (add_wraps) begin
                        r_wrap <= 1'b1;
                    end
                end else begin
                    r_wp   <= '0;
                    r_wrap <= 1'b0;
                end
            end
            r_rd_pend <= i_cmd.scan_step;
            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_key      <= {i_src, i_seq};
            r_scan_idx <= '0;
            r_not_seen <= (i_mode == mcrc_pkg::MODE_CHECK);
        end else begin
            if (i_cmd.scan_step) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (r_rd_pend && (ram_rdata == r_key)) begin
                r_not_seen <= 1'b0;
            end
        end
        if (i_cmd.result_load) begin
            r_out_not_seen <= r_not_seen;
            r_out_count    <= mcrc_pkg::VCNT_W'(len);
        end
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.len_zero  = (len == '0);
    assign o_sts.scan_last = (r_scan_idx == len - 1'b1);
    assign o_sts.out_free  = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_not_seen    = r_out_not_seen;
    assign o_valid_count = r_out_count;

    a_wp_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_wp) <= mcrc_pkg::CACHE_DEPTH)
        else $error("write position beyond cache depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (r_scan_idx < len))
        else $error("scan reads past valid entries");

    a_no_write_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step || r_rd_pend) |-> !ram_we)
        else $error("entry written during scan");

endmodule

// ----- rtl/message_cache_ring_check_top.sv -----
`timescale 1ns / 1ps
// Sequence: add, clear, unused mode and a check over no entries pass from accept
// through execute to the result state; a check over L valid entries (1 <= L <= 32)
// passes the scan and last states between. A new item is accepted only after the
// previous result is loaded, and the scan reads the entry memory one entry per cycle
// through its single read port. Reset (synchronous, active low) empties the ring,
// sets the ring size to 32 and clears the handshakes; entry memory is not cleared.
module message_cache_ring_check_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mcrc_pkg::MODE_W-1:0]   i_mode,
    input  logic [mcrc_pkg::SRC_W-1:0]    i_src,
    input  logic [mcrc_pkg::SEQ_W-1:0]    i_seq,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_not_seen,
    output logic [mcrc_pkg::VCNT_W-1:0]   o_valid_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mcrc_pkg::CFG_W-1:0]    i_cfg_data
);

    mcrc_pkg::t_cmd cmd;
    mcrc_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    mcrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mcrc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_src         (i_src),
        .i_seq         (i_seq),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_not_seen    (o_not_seen),
        .o_valid_count (o_valid_count)
    );

endmodule

// ----- verif/message_cache_ring_check_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the message cache ring check block.
module message_cache_ring_check_top_test;

    localparam logic [mcrc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_PHASES   = 8;
    localparam int OPS_PER_PHASE   = 200;
    localparam int PRESSURE_PHASE  = 6;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RECENT_MAX      = 48;

    typedef struct {
        logic [mcrc_pkg::MODE_W-1:0] mode;
        logic [mcrc_pkg::SRC_W-1:0]  src;
        logic [mcrc_pkg::SEQ_W-1:0]  seq;
    } t_cache_op;

    typedef struct {
        logic                        not_seen;
        logic [mcrc_pkg::VCNT_W-1:0] valid_count;
    } t_cache_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [mcrc_pkg::MODE_W-1:0]  i_mode = '0;
    logic [mcrc_pkg::SRC_W-1:0]   i_src = '0;
    logic [mcrc_pkg::SEQ_W-1:0]   i_seq = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_not_seen;
    logic [mcrc_pkg::VCNT_W-1:0]  o_valid_count;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [mcrc_pkg::CFG_W-1:0]   i_cfg_data = '0;

    t_cache_op                    pending_ops[$];
    t_cache_op                    offered_op;
    t_cache_result                expected_results[$];
    logic [mcrc_pkg::KEY_W-1:0]   recent_keys[$];

    logic [mcrc_pkg::KEY_W-1:0]   stored_keys [mcrc_pkg::CACHE_DEPTH];
    bit                           slot_written [mcrc_pkg::CACHE_DEPTH];
    int                           write_slot = 0;
    bit                           ring_wrapped = 1'b0;
    logic [mcrc_pkg::CFG_W-1:0]   ring_cfg = mcrc_pkg::CFG_RESET;

    int                           tx_idle_pct = 0;
    int                           rx_idle_pct = 0;
    bit                           pressure_req = 1'b0;
    logic                         rx_hold = 1'b0;
    int                           mismatches = 0;
    int                           cycle_count = 0;
    logic [mcrc_pkg::CFG_W-1:0]   phase_ring [RANDOM_PHASES];

    message_cache_ring_check_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_src         (i_src),
        .i_seq         (i_seq),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_not_seen    (o_not_seen),
        .o_valid_count (o_valid_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int ring_len(input logic [mcrc_pkg::CFG_W-1:0] cfg);
        if (cfg == '0) begin
            return 1;
        end
        if (int'(cfg) > mcrc_pkg::CACHE_DEPTH) begin
            return mcrc_pkg::CACHE_DEPTH;
        end
        return int'(cfg);
    endfunction

    function automatic int live_entries();
        int n;
        n = ring_len(ring_cfg);
        if (ring_wrapped) begin
            return n;
        end
        return (write_slot < n) ? write_slot : n;
    endfunction

    task automatic apply_cache_op(input t_cache_op op);
        t_cache_result              res;
        logic [mcrc_pkg::KEY_W-1:0] key;
        int                         n;
        key = {op.src, op.seq};
        res.not_seen = 1'b0;
        case (op.mode)
            mcrc_pkg::MODE_ADD: begin
                if (write_slot >= ring_len(ring_cfg)) begin
                    write_slot = 0;
                    ring_wrapped = 1'b1;
                end
                if (write_slot < mcrc_pkg::CACHE_DEPTH) begin
                    stored_keys[write_slot] = key;
                    slot_written[write_slot] = 1'b1;
                end
                write_slot++;
            end
            mcrc_pkg::MODE_CHECK: begin
                n = live_entries();
                res.not_seen = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (stored_keys[i] == key) begin
                        res.not_seen = 1'b0;
                    end
                end
            end
            mcrc_pkg::MODE_CLEAR: begin
                write_slot = 0;
                ring_wrapped = 1'b0;
            end
            default: begin
            end
        endcase
        res.valid_count = mcrc_pkg::VCNT_W'(live_entries());
        expected_results.push_back(res);
    endtask

    task automatic push_op(input logic [mcrc_pkg::MODE_W-1:0] mode,
                           input logic [mcrc_pkg::SRC_W-1:0] src,
                           input logic [mcrc_pkg::SEQ_W-1:0] seq);
        t_cache_op op;
        op.mode = mode;
        op.src  = src;
        op.seq  = seq;
        pending_ops.push_back(op);
    endtask

    function automatic logic [mcrc_pkg::KEY_W-1:0] fresh_key();
        if ($urandom_range(99) < 20) begin
            return {mcrc_pkg::SRC_W'($urandom_range(3)), mcrc_pkg::SEQ_W'($urandom_range(3))};
        end
        return {mcrc_pkg::SRC_W'($urandom), mcrc_pkg::SEQ_W'($urandom)};
    endfunction

    function automatic logic [mcrc_pkg::KEY_W-1:0] recent_key();
        return recent_keys[$urandom_range(recent_keys.size() - 1)];
    endfunction

    task automatic push_random_op();
        int                         r;
        int                         k;
        logic [mcrc_pkg::KEY_W-1:0] key;
        r = $urandom_range(99);
        k = $urandom_range(99);
        if (r < 1) begin
            key = fresh_key();
            push_op(mcrc_pkg::MODE_CLEAR, key[mcrc_pkg::KEY_W-1:mcrc_pkg::SEQ_W],
                    key[mcrc_pkg::SEQ_W-1:0]);
        end else if (r < 3) begin
            key = fresh_key();
            push_op(MODE_UNUSED, key[mcrc_pkg::KEY_W-1:mcrc_pkg::SEQ_W],
                    key[mcrc_pkg::SEQ_W-1:0]);
        end else if (r < 55) begin
            if (recent_keys.size() != 0 && k < 30) begin
                key = recent_key();
            end else begin
                key = fresh_key();
            end
            recent_keys.push_back(key);
            if (recent_keys.size() > RECENT_MAX) begin
                void'(recent_keys.pop_front());
            end
            push_op(mcrc_pkg::MODE_ADD, key[mcrc_pkg::KEY_W-1:mcrc_pkg::SEQ_W],
                    key[mcrc_pkg::SEQ_W-1:0]);
        end else begin
            if (recent_keys.size() != 0 && k < 50) begin
                key = recent_key();
            end else if (recent_keys.size() != 0 && k < 70) begin
                key = recent_key();
                key[$urandom_range(mcrc_pkg::KEY_W - 1)] ^= 1'b1;
            end else begin
                key = fresh_key();
            end
            push_op(mcrc_pkg::MODE_CHECK, key[mcrc_pkg::KEY_W-1:mcrc_pkg::SEQ_W],
                    key[mcrc_pkg::SEQ_W-1:0]);
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    task automatic write_ring_size(input logic [mcrc_pkg::CFG_W-1:0] value);
        bit safe;
        wait_idle();
        safe = 1'b1;
        for (int i = 0; i < ring_len(value); i++) begin
            if (!slot_written[i]) begin
                safe = 1'b0;
            end
        end
        // drop the wrapped ring so a larger size never exposes unwritten slots
        if (ring_wrapped && !safe) begin
            push_op(mcrc_pkg::MODE_CLEAR, '0, '0);
            wait_idle();
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        ring_cfg = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                apply_cache_op(offered_op);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered_op = pending_ops.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode     <= offered_op.mode;
                    i_src      <= offered_op.src;
                    i_seq      <= offered_op.seq;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat: not_seen %0d valid_count %0d",
                             $time, o_not_seen, o_valid_count);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_not_seen !== want.not_seen) begin
                        $display("%0t: not_seen mismatch: expected %0d, actual %0d",
                                 $time, want.not_seen, o_not_seen);
                        mismatches++;
                    end
                    if (o_valid_count !== want.valid_count) begin
                        $display("%0t: valid_count mismatch: expected %0d, actual %0d",
                                 $time, want.valid_count, o_valid_count);
                        mismatches++;
                    end
                end
            end
            i_out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial begin
        wait (pressure_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("message_cache_ring_check_top test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < mcrc_pkg::CACHE_DEPTH; i++) begin
            stored_keys[i]  = '0;
            slot_written[i] = 1'b0;
        end
        phase_ring = '{6'd63, 6'd3, 6'd0, 6'd32, 6'd33, 6'd2,
                       mcrc_pkg::CFG_W'($urandom_range(1, 63)), 6'd17};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_op(mcrc_pkg::MODE_CHECK, 16'h0000, 24'h000000);
        push_op(mcrc_pkg::MODE_ADD,   16'h0000, 24'h000000);
        push_op(mcrc_pkg::MODE_ADD,   16'hFFFF, 24'hFFFFFF);
        push_op(mcrc_pkg::MODE_ADD,   16'h5555, 24'hAAAAAA);
        push_op(mcrc_pkg::MODE_ADD,   16'hAAAA, 24'h555555);
        push_op(mcrc_pkg::MODE_CHECK, 16'h0000, 24'h000000);
        push_op(mcrc_pkg::MODE_CHECK, 16'hFFFF, 24'hFFFFFF);
        push_op(mcrc_pkg::MODE_CHECK, 16'hFFFF, 24'hFFFFFE);
        push_op(mcrc_pkg::MODE_CHECK, 16'h7FFF, 24'hFFFFFF);
        push_op(MODE_UNUSED,          16'hFFFF, 24'hFFFFFF);

        // shrink below the write position, then wrap
        write_ring_size(6'd2);
        push_op(mcrc_pkg::MODE_CHECK, 16'h5555, 24'hAAAAAA);
        push_op(mcrc_pkg::MODE_ADD,   16'h1234, 24'hABCDEF);
        push_op(mcrc_pkg::MODE_CHECK, 16'h0000, 24'h000000);
        push_op(mcrc_pkg::MODE_CHECK, 16'hFFFF, 24'hFFFFFF);
        push_op(mcrc_pkg::MODE_CLEAR, 16'h0000, 24'h000000);
        push_op(mcrc_pkg::MODE_CHECK, 16'hFFFF, 24'hFFFFFF);

        write_ring_size(6'd1);
        push_op(mcrc_pkg::MODE_ADD,   16'h0001, 24'h000001);
        push_op(mcrc_pkg::MODE_ADD,   16'h0002, 24'h000002);
        push_op(mcrc_pkg::MODE_CHECK, 16'h0001, 24'h000001);
        push_op(mcrc_pkg::MODE_CHECK, 16'h0002, 24'h000002);

        write_ring_size(6'd0);
        push_op(mcrc_pkg::MODE_ADD,   16'h0003, 24'h000003);
        push_op(mcrc_pkg::MODE_CHECK, 16'h0003, 24'h000003);
        push_op(mcrc_pkg::MODE_CLEAR, 16'h0000, 24'h000000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_ring_size(phase_ring[p]);
            if (p < 3) begin
                tx_idle_pct = 29;
                rx_idle_pct = 55;
            end else if (p < 6) begin
                tx_idle_pct = 55;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < OPS_PER_PHASE; n++) begin
                push_random_op();
            end
            if (p == PRESSURE_PHASE) begin
                pressure_req = 1'b1;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("message_cache_ring_check_top test passed");
        end else begin
            $display("message_cache_ring_check_top test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mcrc_pkg.sv
rtl/mcrc_ram.sv
rtl/mcrc_ctrl.sv
rtl/mcrc_dp.sv
rtl/message_cache_ring_check_top.sv
verif/message_cache_ring_check_top_test.sv
